[rtl/u8est_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8est_pkg
// Shared types and codes for the UTF-8 / escape sequence tokenizer.
// ----------------------------------------------------------------------------
package u8est_pkg;

   localparam int unsigned MAX_SYMBOL_BYTES_DEFAULT = 127;
   localparam int unsigned COUNT_MAX                = 127;

   // bytes with a role in the grammar
   localparam logic [7:0] BYTE_ESC  = 8'h1B;
   localparam logic [7:0] BYTE_CSI  = 8'h5B;
   localparam logic [7:0] BYTE_OSC  = 8'h5D;
   localparam logic [7:0] BYTE_SEMI = 8'h3B;
   localparam logic [7:0] BYTE_DEL  = 8'h7F;
   localparam logic [7:0] BYTE_CUU  = 8'h41;

   // symbol kinds
   localparam logic [2:0] KIND_ASCII   = 3'd0;
   localparam logic [2:0] KIND_CONTROL = 3'd1;
   localparam logic [2:0] KIND_ESCAPE  = 3'd2;
   localparam logic [2:0] KIND_UTF8    = 3'd3;
   localparam logic [2:0] KIND_INVALID = 3'd4;

   // escape classes
   localparam logic [2:0] CLASS_NONE = 3'd0;
   localparam logic [2:0] CLASS_CSI  = 3'd1;
   localparam logic [2:0] CLASS_OSC  = 3'd2;
   localparam logic [2:0] CLASS_FE   = 3'd3;
   localparam logic [2:0] CLASS_FS   = 3'd4;
   localparam logic [2:0] CLASS_FP   = 3'd5;
   localparam logic [2:0] CLASS_NF   = 3'd6;

   // command codes
   localparam logic [5:0] CMD_NONE     = 6'd0;
   localparam logic [5:0] CMD_DEL      = 6'd33;
   localparam logic [5:0] CMD_CSI_BASE = 6'd34;  // A..H
   localparam logic [5:0] CMD_CSI_ED   = 6'd42;
   localparam logic [5:0] CMD_CSI_EL   = 6'd43;
   localparam logic [5:0] CMD_CSI_SU   = 6'd44;
   localparam logic [5:0] CMD_CSI_SD   = 6'd45;
   localparam logic [5:0] CMD_CSI_HVP  = 6'd46;
   localparam logic [5:0] CMD_CSI_SGR  = 6'd47;
   localparam logic [5:0] CMD_CSI_TILD = 6'd48;
   localparam logic [5:0] CMD_FE_SS2   = 6'd49;
   localparam logic [5:0] CMD_FE_SS3   = 6'd50;
   localparam logic [5:0] CMD_FE_DCS   = 6'd51;
   localparam logic [5:0] CMD_FE_ST    = 6'd52;
   localparam logic [5:0] CMD_FE_SOS   = 6'd53;
   localparam logic [5:0] CMD_FE_PM    = 6'd54;
   localparam logic [5:0] CMD_FE_APC   = 6'd55;

   typedef struct packed {
      logic [7:0] in_byte;
   } u8est_req_type;

   typedef struct packed {
      logic [2:0]  symbol_kind;
      logic        ended_in_error;
      logic [2:0]  escape_class;
      logic [5:0]  command_code;
      logic [6:0]  byte_count;
      logic [15:0] param_first;
      logic [15:0] param_second;
   } u8est_rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] esc_class;
      logic [5:0] command;
   } u8est_decode_type;

endpackage

[rtl/u8est_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8est_stream_if
// Valid/ready stream channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface u8est_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/u8est_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8est_classify
// Symbol decode: kind from the lead byte, escape class from the second byte,
// command code from the final byte (from the lead byte for control symbols).
// ----------------------------------------------------------------------------
module u8est_classify (
   input  logic [7:0]                  lead_byte,
   input  logic [7:0]                  second_byte,
   input  logic [7:0]                  last_byte,
   input  logic                        multi_byte,
   output u8est_pkg::u8est_decode_type decode
);
   import u8est_pkg::*;

   logic [2:0] kind;
   logic [2:0] byte_class;
   logic [2:0] esc_class;
   logic [5:0] csi_cmd;
   logic [5:0] fe_cmd;
   logic [5:0] command;

   always_comb begin
      unique case (lead_byte) inside
         [8'h20:8'h7E]:                           kind = KIND_ASCII;
         BYTE_ESC:                                kind = KIND_ESCAPE;
         [8'h00:8'h1A], [8'h1C:8'h1F], BYTE_DEL:  kind = KIND_CONTROL;
         [8'hC2:8'hF4]:                           kind = KIND_UTF8;
         default:                                 kind = KIND_INVALID;
      endcase
   end

   always_comb begin
      unique case (second_byte) inside
         BYTE_CSI:                              byte_class = CLASS_CSI;
         BYTE_OSC:                              byte_class = CLASS_OSC;
         [8'h40:8'h5A], 8'h5C, [8'h5E:8'h5F]:   byte_class = CLASS_FE;
         [8'h60:8'h7E]:                         byte_class = CLASS_FS;
         [8'h30:8'h3F]:                         byte_class = CLASS_FP;
         [8'h20:8'h2F]:                         byte_class = CLASS_NF;
         default:                               byte_class = CLASS_NONE;
      endcase
   end

   assign esc_class = (kind == KIND_ESCAPE && multi_byte) ? byte_class : CLASS_NONE;

   always_comb begin
      unique case (last_byte) inside
         [8'h41:8'h48]: csi_cmd = CMD_CSI_BASE + 6'(last_byte - BYTE_CUU);
         8'h4A:         csi_cmd = CMD_CSI_ED;
         8'h4B:         csi_cmd = CMD_CSI_EL;
         8'h53:         csi_cmd = CMD_CSI_SU;
         8'h54:         csi_cmd = CMD_CSI_SD;
         8'h66:         csi_cmd = CMD_CSI_HVP;
         8'h6D:         csi_cmd = CMD_CSI_SGR;
         8'h7E:         csi_cmd = CMD_CSI_TILD;
         default:       csi_cmd = CMD_NONE;
      endcase
   end

   always_comb begin
      unique case (last_byte)
         8'h4E:   fe_cmd = CMD_FE_SS2;
         8'h4F:   fe_cmd = CMD_FE_SS3;
         8'h50:   fe_cmd = CMD_FE_DCS;
         8'h5C:   fe_cmd = CMD_FE_ST;
         8'h58:   fe_cmd = CMD_FE_SOS;
         8'h5E:   fe_cmd = CMD_FE_PM;
         8'h5F:   fe_cmd = CMD_FE_APC;
         default: fe_cmd = CMD_NONE;
      endcase
   end

   always_comb begin
      command = CMD_NONE;
      if (kind == KIND_CONTROL) begin
         // C0 codes map to byte + 1, DEL has its own code
         command = (lead_byte == BYTE_DEL) ? CMD_DEL : 6'(lead_byte[4:0]) + 6'd1;
      end else if (esc_class == CLASS_CSI) begin
         command = csi_cmd;
      end else if (esc_class == CLASS_FE) begin
         command = fe_cmd;
      end
   end

   assign decode.kind      = kind;
   assign decode.esc_class = esc_class;
   assign decode.command   = command;

endmodule

[rtl/utf8_escape_sequence_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_escape_sequence_tokenizer_core
// Splits a terminal byte stream into symbols (ASCII, control, UTF-8, escape
// sequences) and emits one descriptor word per finished symbol.
//
//   channel   dir  payload          word
//   req_chan  in   u8est_req_type   one raw stream byte
//   rsp_chan  out  u8est_rsp_type   one symbol descriptor
//
// One byte per clock. Each byte updates the parser state in the cycle it is
// taken; a byte that ends a symbol loads the descriptor into the output
// register, visible the next cycle. req_chan.ready is low only while a
// descriptor is held and rsp_chan.ready is low. Synchronous reset returns
// the parser to the start state and drops any held descriptor.
// ----------------------------------------------------------------------------
module utf8_escape_sequence_tokenizer_core #(
   parameter int unsigned MAX_SYMBOL_BYTES = u8est_pkg::MAX_SYMBOL_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   u8est_stream_if.sink          req_chan,
   u8est_stream_if.source        rsp_chan
);
   import u8est_pkg::*;

   localparam logic [6:0] COUNT_LIMIT =
      (MAX_SYMBOL_BYTES < COUNT_MAX) ? 7'(MAX_SYMBOL_BYTES) : 7'(COUNT_MAX);

   typedef enum logic [3:0] {
      ST_START     = 4'd0,
      ST_FSEQ      = 4'd1,
      ST_CSI       = 4'd2,
      ST_CSI_INTER = 4'd3,
      ST_NF        = 4'd4,
      ST_U2_1      = 4'd5,
      ST_U3_1      = 4'd6,
      ST_U3_2      = 4'd7,
      ST_U4_1      = 4'd8,
      ST_U4_2      = 4'd9,
      ST_U4_3      = 4'd10
   } state_type;

   state_type        state_ff, state_in, state_nx;
   logic [7:0]       lead_ff, lead_in;
   logic [7:0]       second_ff, second_in;
   logic [6:0]       count_ff, count_in, count_base;
   logic [1:0]       sep_ff, sep_in, sep_base;
   logic [15:0]      param_a_ff, param_a_in, param_a_base;
   logic [15:0]      param_b_ff, param_b_in, param_b_base;
   logic             rsp_valid_ff;
   u8est_rsp_type    rsp_payload_ff, rsp_payload_in;

   logic             accept;
   logic             at_start;
   logic [7:0]       in_byte;
   logic             is_digit;
   logic [3:0]       digit;
   logic             sym_end;
   logic             sym_err;
   logic             sym_done;
   u8est_decode_type decode;

   assign in_byte  = req_chan.payload.in_byte;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;
   // unused state codes behave as the start state
   assign at_start = (state_ff == ST_START) || (state_ff > ST_U4_3);

   // digit accumulate: acc * 10 + d, saturating at 16 bits
   function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [3:0] d);
      logic [19:0] wide;
      wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
      acc_digit = (wide > 20'hFFFF) ? 16'hFFFF : wide[15:0];
   endfunction

   // per-symbol fields restart on the first byte
   always_comb begin
      lead_in      = at_start ? in_byte : lead_ff;
      second_in    = at_start ? 8'd0 : ((count_ff == 7'd1) ? in_byte : second_ff);
      count_base   = at_start ? 7'd0 : count_ff;
      sep_base     = at_start ? 2'd0 : sep_ff;
      param_a_base = at_start ? 16'd0 : param_a_ff;
      param_b_base = at_start ? 16'd0 : param_b_ff;
      count_in     = (count_base < COUNT_LIMIT) ? count_base + 7'd1 : count_base;
   end

   // parameter scan runs over every byte of every symbol
   assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
   assign digit    = in_byte[3:0];

   always_comb begin
      sep_in     = sep_base;
      param_a_in = param_a_base;
      param_b_in = param_b_base;
      if (in_byte == BYTE_SEMI) begin
         if (sep_base != 2'd2) sep_in = sep_base + 2'd1;
      end else if (is_digit) begin
         if (sep_base == 2'd0)      param_a_in = acc_digit(param_a_base, digit);
         else if (sep_base == 2'd1) param_b_in = acc_digit(param_b_base, digit);
      end
   end

   // grammar
   always_comb begin
      state_nx = ST_START;
      sym_end  = 1'b0;
      sym_err  = 1'b0;
      unique case (state_ff)
         ST_FSEQ: begin
            if (in_byte < 8'h20 || in_byte >= BYTE_DEL || in_byte == BYTE_OSC) sym_err = 1'b1;
            else if (in_byte == BYTE_CSI) state_nx = ST_CSI;
            else if (in_byte <= 8'h2F)   state_nx = ST_NF;
            else                         sym_end  = 1'b1;
         end
         ST_CSI: begin
            case (in_byte) inside
               [8'h40:8'h7E]: sym_end  = 1'b1;
               [8'h30:8'h3F]: state_nx = ST_CSI;
               [8'h20:8'h2F]: state_nx = ST_CSI_INTER;
               default:       sym_err  = 1'b1;
            endcase
         end
         ST_CSI_INTER: begin
            case (in_byte) inside
               [8'h40:8'h7E]: sym_end  = 1'b1;
               [8'h20:8'h2F]: state_nx = ST_CSI_INTER;
               default:       sym_err  = 1'b1;
            endcase
         end
         ST_NF: begin
            case (in_byte) inside
               [8'h20:8'h2F]: state_nx = ST_NF;
               [8'h30:8'h7E]: sym_end  = 1'b1;
               default:       sym_err  = 1'b1;
            endcase
         end
         ST_U2_1, ST_U3_2, ST_U4_3: begin
            if (in_byte[7:6] == 2'b10) sym_end = 1'b1;
            else                       sym_err = 1'b1;
         end
         ST_U3_1: begin
            if (in_byte[7:6] == 2'b10) state_nx = ST_U3_2;
            else                       sym_err  = 1'b1;
         end
         ST_U4_1: begin
            if (in_byte[7:6] == 2'b10) state_nx = ST_U4_2;
            else                       sym_err  = 1'b1;
         end
         ST_U4_2: begin
            if (in_byte[7:6] == 2'b10) state_nx = ST_U4_3;
            else                       sym_err  = 1'b1;
         end
         default: begin
            case (in_byte) inside
               BYTE_ESC:      state_nx = ST_FSEQ;
               [8'h00:8'h7F]: sym_end  = 1'b1;
               [8'hC2:8'hDF]: state_nx = ST_U2_1;
               [8'hE0:8'hEF]: state_nx = ST_U3_1;
               [8'hF0:8'hF4]: state_nx = ST_U4_1;
               default:       sym_err  = 1'b1;
            endcase
         end
      endcase
   end

   assign sym_done = sym_end || sym_err;
   assign state_in = sym_done ? ST_START : state_nx;

   u8est_classify u_classify (
      .lead_byte   (lead_in),
      .second_byte (second_in),
      .last_byte   (in_byte),
      .multi_byte  (!at_start),
      .decode      (decode)
   );

   always_comb begin
      rsp_payload_in.symbol_kind    = decode.kind;
      rsp_payload_in.ended_in_error = sym_err;
      rsp_payload_in.escape_class   = decode.esc_class;
      rsp_payload_in.command_code   = decode.command;
      rsp_payload_in.byte_count     = count_in;
      rsp_payload_in.param_first    = param_a_in;
      rsp_payload_in.param_second   = param_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff   <= state_in;
            lead_ff    <= lead_in;
            second_ff  <= second_in;
            count_ff   <= count_in;
            sep_ff     <= sep_in;
            param_a_ff <= param_a_in;
            param_b_ff <= param_b_in;
         end
         if (accept && sym_done) begin
            rsp_valid_ff   <= 1'b1;
            rsp_payload_ff <= rsp_payload_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   a_reset_to_start: assert property (@(posedge clock)
      reset |=> (state_ff == ST_START && !rsp_valid_ff))
      else $error("parser not idle after reset");

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      (accept && sym_done) |=> (rsp_valid_ff && rsp_payload_ff.byte_count != 7'd0))
      else $error("finished symbol produced no descriptor");

   a_class_needs_escape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.escape_class != CLASS_NONE)
         |-> (rsp_payload_ff.symbol_kind == KIND_ESCAPE))
      else $error("escape class on a non-escape symbol");

   a_command_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.command_code != CMD_NONE)
         |-> (rsp_payload_ff.symbol_kind == KIND_CONTROL
              || rsp_payload_ff.symbol_kind == KIND_ESCAPE))
      else $error("command code on a symbol kind that has none");

   a_mid_symbol_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && !sym_done && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("descriptor appeared in the middle of a symbol");

endmodule

[bench/tb_utf8_escape_sequence_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_escape_sequence_tokenizer_core
// Self-checking bench for the terminal byte tokenizer. A driver feeds stream
// bytes from a queue that is filled with corner-case symbols first and then
// with random symbol mixes: printables, controls, UTF-8 runs, and escape
// sequences. Some of these are cut short by stray bytes. Every accepted byte
// goes through a behavioral tokenizer that queues the descriptor it should
// produce. A monitor checks each descriptor word, field by field, in order.
// Both channels stall at random. The sender drains the block now and then.
// ----------------------------------------------------------------------------
module tb_utf8_escape_sequence_tokenizer_core;
   import u8est_pkg::*;

   localparam int SYMBOL_LIMIT = (MAX_SYMBOL_BYTES_DEFAULT < COUNT_MAX) ?
                                 MAX_SYMBOL_BYTES_DEFAULT : COUNT_MAX;
   localparam int STALL_LIMIT  = 5000;
   localparam int CHUNK_BYTES  = 150;
   localparam int CHUNKS       = 6;
   localparam int TAIL_CYCLES  = 10;
   localparam int IDLE_PCT     = 29;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_ESC, SCAN_CSI, SCAN_CSI_INTER, SCAN_NF,
      SCAN_U2_LAST, SCAN_U3_MID, SCAN_U3_LAST, SCAN_U4_MID1, SCAN_U4_MID2,
      SCAN_U4_LAST, SCAN_DONE, SCAN_BROKEN
   } scan_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8est_stream_if #(.payload_type(u8est_req_type)) req_if ();
   u8est_stream_if #(.payload_type(u8est_rsp_type)) rsp_if ();

   utf8_escape_sequence_tokenizer_core #(
      .MAX_SYMBOL_BYTES(MAX_SYMBOL_BYTES_DEFAULT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [7:0]    stream_bytes [$];
   u8est_rsp_type expected_symbols [$];
   u8est_rsp_type want;

   logic [7:0] csi_finals [15] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
                                   8'h48, 8'h4A, 8'h4B, 8'h53, 8'h54, 8'h66, 8'h6D,
                                   8'h7E};
   logic [7:0] fe_finals [7] = '{8'h4E, 8'h4F, 8'h50, 8'h5C, 8'h58, 8'h5E, 8'h5F};

   // tokenizer shadow state
   scan_state_type scan_state = SCAN_IDLE;
   logic [7:0]     sym_lead   = '0;
   logic [7:0]     sym_second = '0;
   int             sym_len    = 0;
   int             semi_seen  = 0;
   int             num_first  = 0;
   int             num_second = 0;

   int  bytes_queued = 0;
   int  bytes_taken  = 0;
   int  stall_cycles = 0;
   int  error_count  = 0;
   bit  req_fire     = 1'b0;
   wire quiet        = (bytes_taken >= 350) && (bytes_taken < 550);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit between(input logic [7:0] b, input logic [7:0] lo,
                                  input logic [7:0] hi);
      return (b >= lo) && (b <= hi);
   endfunction

   function automatic scan_state_type next_scan(input scan_state_type st,
                                                input logic [7:0] b);
      case (st)
         SCAN_ESC: begin
            if (b < 8'h20 || b >= BYTE_DEL || b == BYTE_OSC) return SCAN_BROKEN;
            if (b == BYTE_CSI) return SCAN_CSI;
            if (b <= 8'h2F) return SCAN_NF;
            return SCAN_DONE;
         end
         SCAN_CSI: begin
            if (between(b, 8'h40, 8'h7E)) return SCAN_DONE;
            if (between(b, 8'h30, 8'h3F)) return SCAN_CSI;
            if (between(b, 8'h20, 8'h2F)) return SCAN_CSI_INTER;
            return SCAN_BROKEN;
         end
         SCAN_CSI_INTER: begin
            if (between(b, 8'h40, 8'h7E)) return SCAN_DONE;
            if (between(b, 8'h20, 8'h2F)) return SCAN_CSI_INTER;
            return SCAN_BROKEN;
         end
         SCAN_NF: begin
            if (between(b, 8'h20, 8'h2F)) return SCAN_NF;
            if (between(b, 8'h30, 8'h7E)) return SCAN_DONE;
            return SCAN_BROKEN;
         end
         SCAN_U2_LAST, SCAN_U3_LAST, SCAN_U4_LAST:
            return between(b, 8'h80, 8'hBF) ? SCAN_DONE : SCAN_BROKEN;
         SCAN_U3_MID:  return between(b, 8'h80, 8'hBF) ? SCAN_U3_LAST : SCAN_BROKEN;
         SCAN_U4_MID1: return between(b, 8'h80, 8'hBF) ? SCAN_U4_MID2 : SCAN_BROKEN;
         SCAN_U4_MID2: return between(b, 8'h80, 8'hBF) ? SCAN_U4_LAST : SCAN_BROKEN;
         default: begin
            if (b == BYTE_ESC) return SCAN_ESC;
            if (b <= BYTE_DEL) return SCAN_DONE;
            if (between(b, 8'hC2, 8'hDF)) return SCAN_U2_LAST;
            if (between(b, 8'hE0, 8'hEF)) return SCAN_U3_MID;
            if (between(b, 8'hF0, 8'hF4)) return SCAN_U4_MID1;
            return SCAN_BROKEN;
         end
      endcase
   endfunction

   function automatic logic [2:0] kind_of(input logic [7:0] b);
      if (between(b, 8'h20, 8'h7E)) return KIND_ASCII;
      if (b == BYTE_ESC) return KIND_ESCAPE;
      if (b <= 8'h1F || b == BYTE_DEL) return KIND_CONTROL;
      if (between(b, 8'hC2, 8'hF4)) return KIND_UTF8;
      return KIND_INVALID;
   endfunction

   function automatic logic [2:0] class_of(input logic [7:0] b);
      if (b == BYTE_CSI) return CLASS_CSI;
      if (b == BYTE_OSC) return CLASS_OSC;
      if (between(b, 8'h40, 8'h5F)) return CLASS_FE;
      if (between(b, 8'h60, 8'h7E)) return CLASS_FS;
      if (between(b, 8'h30, 8'h3F)) return CLASS_FP;
      if (between(b, 8'h20, 8'h2F)) return CLASS_NF;
      return CLASS_NONE;
   endfunction

   function automatic logic [5:0] csi_command(input logic [7:0] b);
      // A..H map onto consecutive codes; low six bits of 'A' are 1
      if (between(b, 8'h41, 8'h48)) return CMD_CSI_BASE + b[5:0] - 6'd1;
      case (b)
         8'h4A:   return CMD_CSI_ED;
         8'h4B:   return CMD_CSI_EL;
         8'h53:   return CMD_CSI_SU;
         8'h54:   return CMD_CSI_SD;
         8'h66:   return CMD_CSI_HVP;
         8'h6D:   return CMD_CSI_SGR;
         8'h7E:   return CMD_CSI_TILD;
         default: return CMD_NONE;
      endcase
   endfunction

   function automatic logic [5:0] fe_command(input logic [7:0] b);
      case (b)
         8'h4E:   return CMD_FE_SS2;
         8'h4F:   return CMD_FE_SS3;
         8'h50:   return CMD_FE_DCS;
         8'h5C:   return CMD_FE_ST;
         8'h58:   return CMD_FE_SOS;
         8'h5E:   return CMD_FE_PM;
         8'h5F:   return CMD_FE_APC;
         default: return CMD_NONE;
      endcase
   endfunction

   function automatic int add_digit(input int acc, input int d);
      int v;
      v = acc * 10 + d;
      return (v > 65535) ? 65535 : v;
   endfunction

   // one accepted stream byte; queues a descriptor when a symbol closes
   task automatic tokenize_byte(input logic [7:0] b);
      scan_state_type from;
      scan_state_type to;
      u8est_rsp_type  sym;
      from = scan_state;
      if (from == SCAN_IDLE) begin
         sym_lead   = b;
         sym_second = '0;
         sym_len    = 0;
         semi_seen  = 0;
         num_first  = 0;
         num_second = 0;
      end else if (sym_len == 1) begin
         sym_second = b;
      end
      if (sym_len < SYMBOL_LIMIT) sym_len++;
      // digits and separators are collected on every kind of symbol
      if (b == BYTE_SEMI) begin
         if (semi_seen < 2) semi_seen++;
      end else if (between(b, 8'h30, 8'h39)) begin
         if (semi_seen == 0) num_first = add_digit(num_first, b - 8'h30);
         else if (semi_seen == 1) num_second = add_digit(num_second, b - 8'h30);
      end
      to = next_scan(from, b);
      if (to == SCAN_DONE || to == SCAN_BROKEN) begin
         scan_state         = SCAN_IDLE;
         sym.symbol_kind    = kind_of(sym_lead);
         sym.ended_in_error = (to == SCAN_BROKEN);
         sym.escape_class   = (sym.symbol_kind == KIND_ESCAPE && from != SCAN_IDLE) ?
                              class_of(sym_second) : CLASS_NONE;
         sym.command_code   = CMD_NONE;
         if (sym.symbol_kind == KIND_CONTROL) begin
            sym.command_code = (sym_lead == BYTE_DEL) ? CMD_DEL : sym_lead[5:0] + 6'd1;
         end else if (sym.symbol_kind == KIND_ESCAPE) begin
            if (sym.escape_class == CLASS_CSI) sym.command_code = csi_command(b);
            else if (sym.escape_class == CLASS_FE) sym.command_code = fe_command(b);
         end
         sym.byte_count   = sym_len[6:0];
         sym.param_first  = num_first[15:0];
         sym.param_second = num_second[15:0];
         expected_symbols.push_back(sym);
      end else begin
         scan_state = to;
      end
   endtask

   task automatic compare_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] pick(input int lo, input int hi);
      int unsigned v;
      v = $urandom_range(hi, lo);
      return v[7:0];
   endfunction

   // occasionally swap in a stray byte to break the sequence
   function automatic logic [7:0] maybe_garble(input logic [7:0] b);
      return ($urandom_range(99, 0) < 6) ? pick(0, 255) : b;
   endfunction

   task automatic put(input logic [7:0] b);
      stream_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_utf8();
      int len;
      len = $urandom_range(4, 2);
      case (len)
         2:       put(pick(8'hC2, 8'hDF));
         3:       put(pick(8'hE0, 8'hEF));
         default: put(pick(8'hF0, 8'hF4));
      endcase
      repeat (len - 1) put(maybe_garble(pick(8'h80, 8'hBF)));
   endtask

   task automatic queue_csi(input int body_len);
      int roll;
      put(BYTE_ESC);
      put(BYTE_CSI);
      repeat (body_len) begin
         roll = $urandom_range(99, 0);
         if (roll < 65) put(pick(8'h30, 8'h39));
         else if (roll < 88) put(BYTE_SEMI);
         else put(maybe_garble(pick(8'h3A, 8'h3F)));
      end
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(2, 1)) put(pick(8'h20, 8'h2F));
      if ($urandom_range(9, 0) < 7) put(csi_finals[$urandom_range(14, 0)]);
      else put(maybe_garble(pick(8'h40, 8'h7E)));
   endtask

   task automatic queue_escape();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 40) begin
         queue_csi($urandom_range(7, 0));
      end else begin
         put(BYTE_ESC);
         if (roll < 55) begin
            if ($urandom_range(9, 0) < 7) put(fe_finals[$urandom_range(6, 0)]);
            else put(pick(8'h40, 8'h5F));
         end else if (roll < 67) begin
            put(pick(8'h60, 8'h7E));
         end else if (roll < 79) begin
            put(pick(8'h30, 8'h3F));
         end else if (roll < 91) begin
            repeat ($urandom_range(2, 1)) put(pick(8'h20, 8'h2F));
            put(maybe_garble(pick(8'h30, 8'h7E)));
         end else if (roll < 95) begin
            put(BYTE_OSC);
         end else begin
            put($urandom_range(1, 0) ? pick(8'h00, 8'h1F) : pick(8'h7F, 8'hFF));
         end
      end
   endtask

   task automatic queue_random_symbol();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 25) put(pick(8'h20, 8'h7E));
      else if (roll < 32) put(($urandom_range(9, 0) == 0) ? BYTE_DEL : pick(8'h00, 8'h1F));
      else if (roll < 52) queue_utf8();
      else if (roll < 93) queue_escape();
      else put(pick(0, 255));
   endtask

   task automatic wait_drained();
      while (bytes_taken != bytes_queued || expected_symbols.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------- driver/monitor

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
         rsp_if.ready   <= 1'b0;
      end else begin
         if (!req_if.valid || req_fire) begin
            if (stream_bytes.size() != 0 && (quiet || $urandom_range(99, 0) >= IDLE_PCT)) begin
               req_if.valid          <= 1'b1;
               req_if.payload.in_byte <= stream_bytes.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         // check the descriptor word before predicting from this edge's byte
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected symbol word, expected none, actual %h", $time,
                        rsp_if.payload);
               error_count++;
            end else begin
               want = expected_symbols.pop_front();
               compare_field("symbol_kind", want.symbol_kind, rsp_if.payload.symbol_kind);
               compare_field("ended_in_error", want.ended_in_error,
                             rsp_if.payload.ended_in_error);
               compare_field("escape_class", want.escape_class, rsp_if.payload.escape_class);
               compare_field("command_code", want.command_code, rsp_if.payload.command_code);
               compare_field("byte_count", want.byte_count, rsp_if.payload.byte_count);
               compare_field("param_first", want.param_first, rsp_if.payload.param_first);
               compare_field("param_second", want.param_second, rsp_if.payload.param_second);
            end
         end
         if (req_if.valid && req_if.ready) begin
            tokenize_byte(req_if.payload.in_byte);
            bytes_taken++;
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      req_fire <= !reset && req_if.valid && req_if.ready;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      stream_bytes = '{
         8'h00, 8'h1F, 8'h7F, 8'h20, 8'h7E, 8'h37,              // control/ascii edges, lone digit
         8'h80, 8'hC1, 8'hFF,                                   // bad lead bytes
         8'hC2, 8'h80, 8'hF4, 8'hBF, 8'h80, 8'hBF, 8'hE0, 8'h41, // utf8 good and cut short
         8'h1B, 8'h5B, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,       // CSI, first param saturates
         8'h3B, 8'h37, 8'h3B, 8'h35, 8'h48,                     // third param ignored
         8'h1B, 8'h5D, 8'h1B, 8'h4E, 8'h1B, 8'h28, 8'h42,       // OSC, Fe, nF
         8'h1B, 8'h1B                                           // escape broken by escape
      };
      bytes_queued += stream_bytes.size();
      wait_drained();

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         // one oversized CSI to push the byte count into saturation
         if (chunk == 2) queue_csi(130);
         while (stream_bytes.size() < CHUNK_BYTES) queue_random_symbol();
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[utf8_escape_sequence_tokenizer_core.f]
rtl/u8est_pkg.sv
rtl/u8est_stream_if.sv
rtl/u8est_classify.sv
rtl/utf8_escape_sequence_tokenizer_core.sv
bench/tb_utf8_escape_sequence_tokenizer_core.sv
